[rtl/rclt_pkg.sv]
// ----------------------------------------------------------------------------
// rclt_pkg
// Shared types and constants of the radial raised-cosine low-pass taper.
// ----------------------------------------------------------------------------
`default_nettype none

package rclt_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_X_BINS    = 3'd0;
    localparam logic [2:0] REG_DU_STEP   = 3'd1;
    localparam logic [2:0] REG_DV_STEP   = 3'd2;
    localparam logic [2:0] REG_PASS_EDGE = 3'd3;
    localparam logic [2:0] REG_STOP_EDGE = 3'd4;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // fixed-point constants
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [16:0] W_ONE   = 17'h10000;
    localparam logic [16:0] T_HALF  = 17'd32768;

    // cosine series divisors and their Q33 reciprocals
    localparam int COS_STEPS = 5;
    localparam logic [6:0] COS_DIV [COS_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [32:0] COS_RCP [COS_STEPS] = '{
        33'(64'h2_0000_0000 / 64'd90),
        33'(64'h2_0000_0000 / 64'd56),
        33'(64'h2_0000_0000 / 64'd30),
        33'(64'h2_0000_0000 / 64'd12),
        33'(64'h2_0000_0000 / 64'd2)
    };

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } smp_t;

    // classified word held in the queue
    typedef struct packed {
        logic [12:0] idx;
        logic [11:0] by;
        smp_t        smp;
    } item_t;

    // weight-path context carried alongside the arithmetic
    typedef struct packed {
        logic        force_w;
        logic [16:0] fixed_w;
        logic        flip;
        smp_t        smp;
    } wctx_t;

endpackage

`default_nettype wire

[rtl/rclt_front.sv]
// ----------------------------------------------------------------------------
// rclt_front
// Maps the column index to a signed-wavenumber magnitude and clamps the row.
// ----------------------------------------------------------------------------
`default_nettype none

module rclt_front #(
    parameter int MAX_X_BINS = 4096,
    parameter int MAX_Y_BINS = 4096
) (
    input  wire [12:0]          x_bins,
    input  wire [11:0]          bin_x,
    input  wire [11:0]          bin_y,
    input  wire rclt_pkg::smp_t smp,
    output rclt_pkg::item_t     item
);

    localparam logic [16:0] X_MAX  = 17'(MAX_X_BINS);
    localparam logic [16:0] Y_HALF = 17'(MAX_Y_BINS / 2);

    logic [16:0] cols_wide;
    logic [12:0] cols;
    logic [12:0] half;
    logic [12:0] bx;

    // saturate column count, then fold upper half to negative wavenumbers
    always_comb begin
        if (x_bins < 13'd2) begin
            cols_wide = 17'd2;
        end else if ({4'b0, x_bins} > X_MAX) begin
            cols_wide = X_MAX;
        end else begin
            cols_wide = {4'b0, x_bins};
        end
        cols = cols_wide[12:0];
        half = cols >> 1;
        bx   = {1'b0, bin_x};
        if (bx < half) begin
            item.idx = bx;
        end else if (bx >= cols) begin
            item.idx = bx - cols;
        end else begin
            item.idx = cols - bx;
        end
        if ({5'b0, bin_y} > Y_HALF) begin
            item.by = Y_HALF[11:0];
        end else begin
            item.by = bin_y;
        end
        item.smp = smp;
    end

endmodule

`default_nettype wire

[rtl/rclt_fifo.sv]
// ----------------------------------------------------------------------------
// rclt_fifo
// Short queue decoupling the front from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rclt_fifo (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  wr_en,
    input  wire rclt_pkg::item_t din,
    input  wire                  rd_en,
    output rclt_pkg::item_t      dout,
    output logic                 full,
    output logic                 empty
);

    localparam int AW = rclt_pkg::FIFO_AW;

    rclt_pkg::item_t mem [rclt_pkg::FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     cnt_reg;
    logic [AW:0]     cnt_next;

    assign full  = (cnt_reg == (AW+1)'(rclt_pkg::FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    // occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !empty) else $error("queue read while empty");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !full) else $error("queue written while full");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(rclt_pkg::FIFO_DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

[rtl/rclt_radius.sv]
// ----------------------------------------------------------------------------
// rclt_radius
// Radial wavenumber: two products, two squares and a bit-per-stage root.
// ----------------------------------------------------------------------------
`default_nettype none

module rclt_radius (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  en,
    input  wire                  in_valid,
    input  wire rclt_pkg::item_t item,
    input  wire [31:0]           du_step,
    input  wire [31:0]           dv_step,
    output logic                 out_valid,
    output logic [31:0]          k,
    output rclt_pkg::smp_t       smp
);

    localparam int ROOT_W = 32;

    // stage 0: per-axis wavenumbers
    logic           v0_reg;
    logic [44:0]    u_reg;
    logic [43:0]    v_reg;
    rclt_pkg::smp_t s0_reg;

    // stage 1: squares
    logic           v1_reg;
    logic [63:0]    su_reg;
    logic [63:0]    sv_reg;
    logic           sat1_reg;
    rclt_pkg::smp_t s1_reg;

    // root pipeline
    logic           rvld_reg [ROOT_W+1];
    logic [65:0]    rem_reg  [ROOT_W+1];
    logic [31:0]    root_reg [ROOT_W+1];
    logic           rsat_reg [ROOT_W+1];
    rclt_pkg::smp_t rsmp_reg [ROOT_W+1];

    logic [64:0]    sum_next;

    assign sum_next = {1'b0, su_reg} + {1'b0, sv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            rvld_reg[0] <= 1'b0;
        end else if (en) begin
            v0_reg      <= in_valid;
            v1_reg      <= v0_reg;
            rvld_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg       <= 45'(item.idx) * 45'(du_step);
            v_reg       <= 44'(item.by) * 44'(dv_step);
            s0_reg      <= item.smp;
            su_reg      <= u_reg[31:0] * u_reg[31:0];
            sv_reg      <= v_reg[31:0] * v_reg[31:0];
            sat1_reg    <= (|u_reg[44:32]) | (|v_reg[43:32]);
            s1_reg      <= s0_reg;
            rem_reg[0]  <= {2'b0, sum_next[63:0]};
            root_reg[0] <= '0;
            rsat_reg[0] <= sat1_reg | sum_next[64];
            rsmp_reg[0] <= s1_reg;
        end
    end

    // one result bit per stage, most significant first
    for (genvar i = 0; i < ROOT_W; i++) begin : g_root
        localparam int B = ROOT_W - 1 - i;
        logic [65:0] trial;
        logic        ge;

        always_comb begin
            trial = (66'(root_reg[i]) << (B + 1)) | (66'd1 << (2 * B));
            ge    = rem_reg[i] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rvld_reg[i+1] <= 1'b0;
            end else if (en) begin
                rvld_reg[i+1] <= rvld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1]  <= ge ? rem_reg[i] - trial : rem_reg[i];
                root_reg[i+1] <= ge ? (root_reg[i] | (32'd1 << B)) : root_reg[i];
                rsat_reg[i+1] <= rsat_reg[i];
                rsmp_reg[i+1] <= rsmp_reg[i];
            end
        end
    end

    // saturate when the radius does not fit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= rvld_reg[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k   <= rsat_reg[ROOT_W] ? 32'hFFFF_FFFF : root_reg[ROOT_W];
            smp <= rsmp_reg[ROOT_W];
        end
    end

endmodule

`default_nettype wire

[rtl/rclt_weight.sv]
// ----------------------------------------------------------------------------
// rclt_weight
// Taper phase by long division, raised-cosine series and sample scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module rclt_weight (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  wire [31:0]          k,
    input  wire rclt_pkg::smp_t smp,
    input  wire [31:0]          pass_edge,
    input  wire [31:0]          stop_edge,
    output logic                out_valid,
    output logic signed [31:0]  result_re,
    output logic signed [31:0]  result_im,
    output logic [16:0]         weight
);

    localparam int DIV_STEPS = 17;
    localparam int NC        = rclt_pkg::COS_STEPS;

    // classification
    logic            below;
    logic            above;
    logic [31:0]     span;
    logic [31:0]     diff;
    rclt_pkg::wctx_t ctx_next;

    always_comb begin
        below            = k < pass_edge;
        above            = k > stop_edge;
        span             = stop_edge - pass_edge;
        diff             = k - pass_edge;
        ctx_next.force_w = below | above | (pass_edge == stop_edge);
        ctx_next.fixed_w = (!below && above) ? 17'd0 : rclt_pkg::W_ONE;
        ctx_next.flip    = 1'b0;
        ctx_next.smp     = smp;
    end

    // division pipeline: phase t = diff * 2^16 / span
    logic            dvld_reg [DIV_STEPS+1];
    logic [48:0]     rem_reg  [DIV_STEPS+1];
    logic [16:0]     quo_reg  [DIV_STEPS+1];
    rclt_pkg::wctx_t dctx_reg [DIV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg[0] <= 1'b0;
        end else if (en) begin
            dvld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {1'b0, diff, 16'b0};
            quo_reg[0]  <= '0;
            dctx_reg[0] <= ctx_next;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int B = DIV_STEPS - 1 - j;
        logic [48:0] trial;
        logic        ge;

        always_comb begin
            trial = 49'(span) << B;
            ge    = rem_reg[j] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvld_reg[j+1] <= 1'b0;
            end else if (en) begin
                dvld_reg[j+1] <= dvld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= ge ? rem_reg[j] - trial : rem_reg[j];
                quo_reg[j+1]  <= {quo_reg[j][15:0], ge};
                dctx_reg[j+1] <= dctx_reg[j];
            end
        end
    end

    // fold the second half of the taper onto the first
    logic            fvld_reg;
    logic [15:0]     th_reg;
    rclt_pkg::wctx_t fctx_reg;
    rclt_pkg::wctx_t fctx_next;
    logic            flip_next;
    logic [16:0]     th_next;

    always_comb begin
        flip_next      = quo_reg[DIV_STEPS] > rclt_pkg::T_HALF;
        th_next        = flip_next ? rclt_pkg::W_ONE - quo_reg[DIV_STEPS] : quo_reg[DIV_STEPS];
        fctx_next      = dctx_reg[DIV_STEPS];
        fctx_next.flip = flip_next;
    end

    // angle x = pi*t (Q2.30), then s = x^2
    logic            xvld_reg;
    logic [31:0]     x_reg;
    rclt_pkg::wctx_t xctx_reg;
    logic [47:0]     xprod;
    logic [63:0]     sq;

    assign xprod = 48'(rclt_pkg::PI_Q30) * 48'(th_reg);
    assign sq    = 64'(x_reg) * 64'(x_reg);

    // cosine series, three stages per term
    logic            cvld_reg [NC+1];
    logic [31:0]     cs_reg   [NC+1];
    logic [30:0]     cp_reg   [NC+1];
    rclt_pkg::wctx_t cctx_reg [NC+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvld_reg    <= 1'b0;
            xvld_reg    <= 1'b0;
            cvld_reg[0] <= 1'b0;
        end else if (en) begin
            fvld_reg    <= dvld_reg[DIV_STEPS];
            xvld_reg    <= fvld_reg;
            cvld_reg[0] <= xvld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            th_reg        <= th_next[15:0];
            fctx_reg      <= fctx_next;
            x_reg         <= xprod[47:16];
            xctx_reg      <= fctx_reg;
            cs_reg[0]     <= sq[61:30];
            cp_reg[0]     <= rclt_pkg::ONE_Q30;
            cctx_reg[0]   <= xctx_reg;
        end
    end

    for (genvar i = 0; i < NC; i++) begin : g_cos
        localparam logic [6:0]  DV = rclt_pkg::COS_DIV[i];
        localparam logic [32:0] RC = rclt_pkg::COS_RCP[i];

        logic            avld_reg;
        logic [31:0]     am_reg;
        logic [31:0]     as_reg;
        rclt_pkg::wctx_t actx_reg;
        logic            bvld_reg;
        logic [31:0]     bm_reg;
        logic [31:0]     bq_reg;
        logic [31:0]     bs_reg;
        rclt_pkg::wctx_t bctx_reg;

        logic [62:0]     aprod;
        logic [64:0]     bprod;
        logic [38:0]     chk;
        logic [31:0]     rsd;
        logic [31:0]     q;
        logic [30:0]     p_next;

        // s*p, reciprocal estimate, then a single correction step
        always_comb begin
            aprod  = 63'(cs_reg[i]) * 63'(cp_reg[i]);
            bprod  = 65'(am_reg) * 65'(RC);
            chk    = 39'(bq_reg) * 39'(DV);
            rsd    = bm_reg - chk[31:0];
            q      = bq_reg + 32'(rsd >= 32'(DV));
            p_next = (q >= 32'(rclt_pkg::ONE_Q30)) ? 31'd0 : 31'(32'(rclt_pkg::ONE_Q30) - q);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                avld_reg      <= 1'b0;
                bvld_reg      <= 1'b0;
                cvld_reg[i+1] <= 1'b0;
            end else if (en) begin
                avld_reg      <= cvld_reg[i];
                bvld_reg      <= avld_reg;
                cvld_reg[i+1] <= bvld_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                am_reg        <= aprod[61:30];
                as_reg        <= cs_reg[i];
                actx_reg      <= cctx_reg[i];
                bm_reg        <= am_reg;
                bq_reg        <= bprod[64:33];
                bs_reg        <= as_reg;
                bctx_reg      <= actx_reg;
                cp_reg[i+1]   <= p_next;
                cs_reg[i+1]   <= bs_reg;
                cctx_reg[i+1] <= bctx_reg;
            end
        end
    end

    // weight from the series, unfolded and overridden for the flat regions
    logic            wvld_reg;
    logic [16:0]     w_reg;
    rclt_pkg::smp_t  wsmp_reg;
    logic [31:0]     wsum;
    logic [16:0]     wh;
    logic [16:0]     w_next;

    always_comb begin
        wsum = 32'(rclt_pkg::ONE_Q30) + 32'(cp_reg[NC]) + 32'h0000_4000;
        wh   = wsum[31:15];
        if (cctx_reg[NC].force_w) begin
            w_next = cctx_reg[NC].fixed_w;
        end else if (cctx_reg[NC].flip) begin
            w_next = rclt_pkg::W_ONE - wh;
        end else begin
            w_next = wh;
        end
    end

    // scaling, rounded half up
    logic signed [49:0] pre_re;
    logic signed [49:0] pre_im;
    logic signed [17:0] w_s;

    always_comb begin
        w_s    = $signed({1'b0, w_reg});
        pre_re = 50'($signed(wsmp_reg.re)) * 50'(w_s) + 50'sd32768;
        pre_im = 50'($signed(wsmp_reg.im)) * 50'(w_s) + 50'sd32768;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvld_reg  <= 1'b0;
            out_valid <= 1'b0;
        end else if (en) begin
            wvld_reg  <= cvld_reg[NC];
            out_valid <= wvld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg     <= w_next;
            wsmp_reg  <= cctx_reg[NC].smp;
            result_re <= pre_re[47:16];
            result_im <= pre_im[47:16];
            weight    <= w_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/radial_cosine_lowpass_taper.sv]
// ----------------------------------------------------------------------------
// radial_cosine_lowpass_taper
// Raised-cosine radial low-pass weighting of complex 2-D spectrum bins.
// ----------------------------------------------------------------------------
// Takes one spectrum word per clock and returns one weighted word per clock
// while m_ready is held high; the path is fully pipelined, the square root
// resolving one result bit per stage and the phase divider one quotient bit
// per stage. A four-word queue sits between the index front end and the
// arithmetic pipeline, and the whole pipeline holds while the output word
// waits to be taken. The user must write registers only while no word is in
// flight; the block itself does not enforce it.
`default_nettype none

module radial_cosine_lowpass_taper #(
    parameter int MAX_X_BINS = 4096,
    parameter int MAX_Y_BINS = 4096
) (
    input  wire                aclk,
    input  wire                aresetn,
    // configuration
    input  wire                cfg_we,
    input  wire [2:0]          cfg_index,
    input  wire [31:0]         cfg_data,
    // input words
    input  wire                s_valid,
    output logic               s_ready,
    input  wire [11:0]         s_bin_x,
    input  wire [11:0]         s_bin_y,
    input  wire signed [31:0]  s_sample_re,
    input  wire signed [31:0]  s_sample_im,
    // result words
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_result_re,
    output logic signed [31:0] m_result_im,
    output logic [16:0]        m_weight
);

    // configuration registers
    logic [12:0] x_bins_reg;
    logic [31:0] du_step_reg;
    logic [31:0] dv_step_reg;
    logic [31:0] pass_edge_reg;
    logic [31:0] stop_edge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_bins_reg    <= 13'd256;
            du_step_reg   <= 32'h0100_0000;
            dv_step_reg   <= 32'h0100_0000;
            pass_edge_reg <= '0;
            stop_edge_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rclt_pkg::REG_X_BINS:    x_bins_reg    <= cfg_data[12:0];
                rclt_pkg::REG_DU_STEP:   du_step_reg   <= cfg_data;
                rclt_pkg::REG_DV_STEP:   dv_step_reg   <= cfg_data;
                rclt_pkg::REG_PASS_EDGE: pass_edge_reg <= cfg_data;
                rclt_pkg::REG_STOP_EDGE: stop_edge_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: index mapping
    rclt_pkg::smp_t  in_smp;
    rclt_pkg::item_t front_item;
    rclt_pkg::item_t q_item;
    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    logic            en;

    assign in_smp.re = s_sample_re;
    assign in_smp.im = s_sample_im;

    rclt_front #(
        .MAX_X_BINS (MAX_X_BINS),
        .MAX_Y_BINS (MAX_Y_BINS)
    ) u_front (
        .x_bins (x_bins_reg),
        .bin_x  (s_bin_x),
        .bin_y  (s_bin_y),
        .smp    (in_smp),
        .item   (front_item)
    );

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // back pipeline advances whenever the output slot is free or drains
    assign en  = m_ready || !m_valid;
    assign pop = en && !q_empty;

    rclt_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .din     (front_item),
        .rd_en   (pop),
        .dout    (q_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    logic           rad_valid;
    logic [31:0]    rad_k;
    rclt_pkg::smp_t rad_smp;

    rclt_radius u_radius (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (!q_empty),
        .item      (q_item),
        .du_step   (du_step_reg),
        .dv_step   (dv_step_reg),
        .out_valid (rad_valid),
        .k         (rad_k),
        .smp       (rad_smp)
    );

    rclt_weight u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rad_valid),
        .k         (rad_k),
        .smp       (rad_smp),
        .pass_edge (pass_edge_reg),
        .stop_edge (stop_edge_reg),
        .out_valid (m_valid),
        .result_re (m_result_re),
        .result_im (m_result_im),
        .weight    (m_weight)
    );

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_weight <= rclt_pkg::W_ONE) else $error("weight above one");
    a_zero_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_weight == 17'd0) |-> (m_result_re == 32'sd0 && m_result_im == 32'sd0))
        else $error("nonzero result under zero weight");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !pop ##1 $stable(rad_k))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire
